[hdl/l4_dest_port_blocklist_filter_assert.svh]
// Assertion macros for the L4 destination port blocklist filter.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef L4_DEST_PORT_BLOCKLIST_FILTER_ASSERT_SVH
`define L4_DEST_PORT_BLOCKLIST_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define L4DPBF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("l4dpbf same-cycle check failed");
`define L4DPBF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("l4dpbf next-cycle check failed");
`else
`define L4DPBF_ASSERT_IMP(label, ante, cons)
`define L4DPBF_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hdl/l4dpbf_pkg.sv]
// Package for the L4 destination port blocklist filter: request and verdict
// structs, sequencer states and protocol constants. No dependencies.
`timescale 1ns / 1ps

package l4dpbf_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [5:0]  entry_index;
    logic [15:0] entry_port;
  } l4dpbf_in_t;

  typedef struct packed {
    logic        drop;
    logic        port_parsed;
    logic [15:0] dest_port;
  } l4dpbf_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } l4dpbf_state_t;

  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_PACKET_BYTE = 1'b1;

  localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFF_IHL      = 16'd14;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;

  localparam logic [16:0] ETH_HDR_LEN = 17'd14;
  localparam logic [16:0] IP_MIN_LEN  = 17'd20;
  localparam logic [16:0] TCP_HDR_LEN = 17'd20;
  localparam logic [16:0] UDP_HDR_LEN = 17'd8;
  localparam logic [16:0] L4_PORT_HI  = 17'd2;
  localparam logic [16:0] L4_PORT_LO  = 17'd3;

  localparam logic [3:0] IHL_MIN   = 4'd5;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

endpackage

[hdl/l4_dest_port_blocklist_filter.sv]
// L4 destination port blocklist filter, top level.
// Depends on l4dpbf_pkg and l4_dest_port_blocklist_filter_assert.svh.
`timescale 1ns / 1ps
`include "l4_dest_port_blocklist_filter_assert.svh"

// Usage
//   Input channel (in_valid/in_ready/in_data) carries two kinds of request:
//   a table write (opcode OP_TABLE_WRITE) that stores entry_port into blocklist
//   slot entry_index, and a packet byte (OP_PACKET_BYTE) of an Ethernet frame,
//   starting at the destination MAC. Each frame yields exactly one verdict on
//   the output channel (out_valid/out_ready/out_data) when its last byte is
//   accepted; table writes and non-final bytes yield nothing.
//   cfg_we/cfg_wdata set blocked_count, the number of leading table entries
//   that are live; write it only while the block is idle.
// Sequencing
//   Table writes and non-final bytes are taken without leaving ST_IDLE. A final
//   byte drops in_ready until the verdict is handed over; with no TCP/UDP port
//   or n zero, n = min(blocked_count, TABLE_DEPTH), it goes straight to ST_DONE,
//   else via the blocklist walk: one memory read per cycle through a single read
//   port, compare in the cycle after, stop early on a hit.
// Reset
//   After rst_n the block runs a clearing pass over all TABLE_DEPTH entries that
//   zeroes the blocklist memory; in_ready stays low until it is done.
// Stall
//   A verdict waits in the output register until taken; a further verdict
//   holds in ST_DONE, with in_ready low, until the register frees up.
module l4_dest_port_blocklist_filter #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  l4dpbf_pkg::l4dpbf_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output l4dpbf_pkg::l4dpbf_out_t  out_data,
  input  logic                     cfg_we,
  input  logic [6:0]               cfg_wdata
);
  import l4dpbf_pkg::*;

  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] LAST_ENTRY = CNTW'(TABLE_DEPTH - 1);

  // Blocklist storage, one write and one registered read per cycle.
  logic [15:0] table_mem [TABLE_DEPTH];

  l4dpbf_state_t state_r, state_nxt;

  logic [6:0]      blocked_count_r;
  logic [CNTW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNTW-1:0] walk_idx_r, walk_idx_nxt;
  logic [CNTW-1:0] live_cnt;

  // Per-frame parse state
  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic        eth_ok_r, eth_ok_nxt;
  logic [3:0]  hdr_words_r, hdr_words_nxt;
  logic [7:0]  ip_proto_r, ip_proto_nxt;
  logic [15:0] port_r, port_nxt;

  // Verdict being resolved
  logic        vd_parsed_r, vd_parsed_nxt;
  logic [15:0] vd_port_r, vd_port_nxt;
  logic        vd_hit_r, vd_hit_nxt;

  // Walk read pipeline
  logic        rd_issue;
  logic [15:0] rd_data_r;
  logic        cmp_vld_r;
  logic        cmp_last_r;
  logic        cmp_hit;

  logic        out_valid_r, out_valid_nxt;
  l4dpbf_out_t out_data_r, out_data_nxt;

  logic        mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [15:0] mem_wdata;

  logic        acc;
  logic        acc_byte;
  logic        acc_write;
  logic        frame_end;
  logic        frame_parsed;
  logic [16:0] off_x;
  logic [16:0] frame_len;
  logic [16:0] l4_start;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign acc_byte  = acc && (in_data.opcode == OP_PACKET_BYTE);
  assign acc_write = acc && (in_data.opcode == OP_TABLE_WRITE);
  assign frame_end = acc_byte && in_data.last_byte;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Live entry count, saturated at the table depth.
  assign live_cnt = (32'(blocked_count_r) > TABLE_DEPTH) ? CNTW'(TABLE_DEPTH)
                                                        : CNTW'(blocked_count_r);

  // ---------------------------------------------------------------------------
  // Byte parser: track offset, EtherType, IHL, protocol and the port bytes.
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_offset_nxt = byte_offset_r;
    eth_ok_nxt      = eth_ok_r;
    hdr_words_nxt   = hdr_words_r;
    ip_proto_nxt    = ip_proto_r;
    port_nxt        = port_r;
    off_x           = {1'b0, byte_offset_r};
    frame_len       = off_x + 17'd1;

    if (byte_offset_r == OFF_ETYPE_HI) begin
      eth_ok_nxt = (in_data.packet_byte == ETYPE_IPV4_HI);
    end else if (byte_offset_r == OFF_ETYPE_LO) begin
      eth_ok_nxt = eth_ok_r && (in_data.packet_byte == ETYPE_IPV4_LO);
    end else if (byte_offset_r == OFF_IHL) begin
      hdr_words_nxt = in_data.packet_byte[3:0];
    end else if (byte_offset_r == OFF_PROTO) begin
      ip_proto_nxt = in_data.packet_byte;
    end

    // L4 header starts after the Ethernet header plus IHL 32-bit words.
    l4_start = ETH_HDR_LEN + {11'd0, hdr_words_nxt, 2'b00};

    if (off_x > ETH_HDR_LEN) begin
      if (off_x == l4_start + L4_PORT_HI) begin
        port_nxt[15:8] = in_data.packet_byte;
      end else if (off_x == l4_start + L4_PORT_LO) begin
        port_nxt[7:0] = in_data.packet_byte;
      end
    end

    if (byte_offset_r != OFFSET_MAX) begin
      byte_offset_nxt = byte_offset_r + 16'd1;
    end

    frame_parsed = 1'b0;
    if (eth_ok_nxt && (frame_len >= ETH_HDR_LEN + IP_MIN_LEN) &&
        (hdr_words_nxt >= IHL_MIN) && (frame_len >= l4_start)) begin
      if (ip_proto_nxt == PROTO_TCP && frame_len >= l4_start + TCP_HDR_LEN) begin
        frame_parsed = 1'b1;
      end else if (ip_proto_nxt == PROTO_UDP &&
                   frame_len >= l4_start + UDP_HDR_LEN) begin
        frame_parsed = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clearing pass, idle intake, blocklist walk, verdict handoff.
  // ---------------------------------------------------------------------------
  assign cmp_hit  = cmp_vld_r && (rd_data_r == vd_port_r);
  assign rd_issue = (state_r == ST_WALK) && (walk_idx_r < live_cnt) &&
                    !(cmp_vld_r && (cmp_hit || cmp_last_r));

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    walk_idx_nxt  = walk_idx_r;
    vd_parsed_nxt = vd_parsed_r;
    vd_port_nxt   = vd_port_r;
    vd_hit_nxt    = vd_hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = IDXW'(in_data.entry_index);
    mem_wdata     = in_data.entry_port;

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry per cycle.
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r[IDXW-1:0];
        mem_wdata   = 16'd0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_ENTRY) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_write && (32'(in_data.entry_index) < TABLE_DEPTH)) begin
          mem_we = 1'b1;
        end
        if (frame_end) begin
          vd_parsed_nxt = frame_parsed;
          vd_port_nxt   = frame_parsed ? port_nxt : 16'd0;
          vd_hit_nxt    = 1'b0;
          walk_idx_nxt  = '0;
          if (frame_parsed && live_cnt != '0) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (rd_issue) begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
        if (cmp_vld_r && (cmp_hit || cmp_last_r)) begin
          vd_hit_nxt = cmp_hit;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the verdict over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.drop      = vd_hit_r;
          out_data_nxt.port_parsed = vd_parsed_r;
          out_data_nxt.dest_port = vd_port_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_idx_r       <= '0;
      blocked_count_r <= 7'd0;
      byte_offset_r   <= 16'd0;
      eth_ok_r        <= 1'b0;
      hdr_words_r     <= 4'd0;
      ip_proto_r      <= 8'd0;
      port_r          <= 16'd0;
      out_valid_r     <= 1'b0;
      cmp_vld_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= rd_issue;
      if (cfg_we) begin
        blocked_count_r <= cfg_wdata;
      end
      if (frame_end) begin
        // Drop the per-frame state after the verdict is captured.
        byte_offset_r <= 16'd0;
        eth_ok_r      <= 1'b0;
        hdr_words_r   <= 4'd0;
        ip_proto_r    <= 8'd0;
        port_r        <= 16'd0;
      end else if (acc_byte) begin
        byte_offset_r <= byte_offset_nxt;
        eth_ok_r      <= eth_ok_nxt;
        hdr_words_r   <= hdr_words_nxt;
        ip_proto_r    <= ip_proto_nxt;
        port_r        <= port_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r  <= walk_idx_nxt;
    vd_parsed_r <= vd_parsed_nxt;
    vd_port_r   <= vd_port_nxt;
    vd_hit_r    <= vd_hit_nxt;
    out_data_r  <= out_data_nxt;
    cmp_last_r  <= (walk_idx_r == live_cnt - 1'b1);
  end

  // Blocklist memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_data_r <= table_mem[walk_idx_r[IDXW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `L4DPBF_ASSERT_NXT(a_frame_end_leaves_idle, frame_end, state_r == ST_WALK || state_r == ST_DONE)
  `L4DPBF_ASSERT_IMP(a_walk_only_parsed, state_r == ST_WALK, vd_parsed_r)
  `L4DPBF_ASSERT_IMP(a_drop_needs_port, out_valid_r && out_data_r.drop, out_data_r.port_parsed)
  `L4DPBF_ASSERT_IMP(a_unparsed_zero_port, out_valid_r && !out_data_r.port_parsed, out_data_r.dest_port == 16'd0)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for l4_dest_port_blocklist_filter: streams blocklist writes and
// Ethernet frame bytes, predicts every drop/pass verdict and compares it with the block.
// Depends on l4dpbf_pkg and the filter RTL; reads no files.

module tb_top;
  import l4dpbf_pkg::*;

  localparam int TABLE_DEPTH = 64;
  // Covers the longest walk plus the output register, with margin.
  localparam int WALK_SLACK  = TABLE_DEPTH + 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_LIMIT = 200;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  l4dpbf_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  l4dpbf_out_t out_data;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  // Requests waiting to go out, oldest first; popped when accepted.
  l4dpbf_in_t  request_q [$];
  // Verdicts the filter owes us, oldest first.
  l4dpbf_out_t verdict_q [$];

  bit idle_on       = 1'b0;
  int error_count   = 0;
  int requests_sent = 0;

  // Shadow copy of the filter state, advanced on each accepted request.
  logic [15:0] frame_off  = '0;
  logic        etype_ok   = 1'b0;
  logic [3:0]  ihl_words  = '0;
  logic [7:0]  ip_proto   = '0;
  logic [15:0] cur_port   = '0;
  logic [6:0]  live_count = '0;
  logic [15:0] port_table [TABLE_DEPTH] = '{default: '0};

  l4_dest_port_blocklist_filter #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Advance the shadow parser by one accepted request; on the last byte of a
  // frame, work out the verdict and queue it.
  function automatic void predict_request(input l4dpbf_in_t req);
    logic [15:0] off;
    logic [16:0] l4_start;
    logic [16:0] flen;
    logic        parsed;
    logic        hit;
    int          live;
    int          i;
    l4dpbf_out_t verdict;

    if (req.opcode == OP_TABLE_WRITE) begin
      // Slot index is 6 bits wide, so it always lands inside the table.
      port_table[req.entry_index] = req.entry_port;
      return;
    end

    off = frame_off;
    if (off == OFF_ETYPE_HI) begin
      etype_ok = (req.packet_byte == ETYPE_IPV4_HI);
    end else if (off == OFF_ETYPE_LO) begin
      etype_ok = etype_ok && (req.packet_byte == ETYPE_IPV4_LO);
    end else if (off == OFF_IHL) begin
      ihl_words = req.packet_byte[3:0];
    end else if (off == OFF_PROTO) begin
      ip_proto = req.packet_byte;
    end

    // IHL is only meaningful once we are past its byte.
    l4_start = ETH_HDR_LEN + (17'(ihl_words) << 2);
    if ({1'b0, off} > ETH_HDR_LEN) begin
      if ({1'b0, off} == l4_start + L4_PORT_HI) begin
        cur_port[15:8] = req.packet_byte;
      end else if ({1'b0, off} == l4_start + L4_PORT_LO) begin
        cur_port[7:0] = req.packet_byte;
      end
    end

    // Hold the offset at its maximum on very long frames.
    if (off != OFFSET_MAX) frame_off = off + 16'd1;

    if (!req.last_byte) return;

    flen   = {1'b0, off} + 17'd1;
    parsed = 1'b0;
    if (etype_ok && flen >= ETH_HDR_LEN + IP_MIN_LEN && ihl_words >= IHL_MIN &&
        flen >= l4_start) begin
      if (ip_proto == PROTO_TCP && flen >= l4_start + TCP_HDR_LEN) begin
        parsed = 1'b1;
      end else if (ip_proto == PROTO_UDP && flen >= l4_start + UDP_HDR_LEN) begin
        parsed = 1'b1;
      end
    end

    // Counts above the table depth cover the whole table.
    live = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
    hit  = 1'b0;
    if (parsed) begin
      for (i = 0; i < live; i++) begin
        if (port_table[i] == cur_port) hit = 1'b1;
      end
    end

    verdict.drop        = hit;
    verdict.port_parsed = parsed;
    verdict.dest_port   = parsed ? cur_port : 16'h0000;
    verdict_q.push_back(verdict);

    // Drop all per-frame state; the table and the count survive.
    frame_off = '0;
    etype_ok  = 1'b0;
    ihl_words = '0;
    ip_proto  = '0;
    cur_port  = '0;
  endfunction

  // Request driver: hold each request until it is taken, then advance to the
  // next one or insert a random gap between requests.
  initial begin : request_driver
    int         gap_left;
    bit         accepted;
    l4dpbf_in_t taken;
    gap_left = 0;
    forever begin
      @(posedge clk);
      accepted = rst_n && in_valid && in_ready;
      if (accepted) begin
        taken = request_q.pop_front();
        predict_request(taken);
      end
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= request_q[0];
        end
      end
    end
  end

  // Result sink: stall the output side in random bursts while idling is on.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Verdict checker: match every taken verdict against the oldest prediction.
  initial begin : verdict_checker
    l4dpbf_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with no frame pending", int'(out_data), 0);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.drop !== want.drop) begin
            report_mismatch("drop", int'(out_data.drop), int'(want.drop));
          end
          if (out_data.port_parsed !== want.port_parsed) begin
            report_mismatch("port_parsed", int'(out_data.port_parsed), int'(want.port_parsed));
          end
          if (out_data.dest_port !== want.dest_port) begin
            report_mismatch("dest_port", int'(out_data.dest_port), int'(want.dest_port));
          end
        end
      end
    end
  end

  task automatic queue_table_write(input logic [5:0] idx, input logic [15:0] port);
    l4dpbf_in_t req;
    req.opcode      = OP_TABLE_WRITE;
    req.packet_byte = 8'($urandom);
    req.last_byte   = 1'($urandom);
    req.entry_index = idx;
    req.entry_port  = port;
    request_q.push_back(req);
    requests_sent++;
  endtask

  task automatic queue_packet_byte(input logic [7:0] data_byte, input logic last);
    l4dpbf_in_t req;
    req.opcode      = OP_PACKET_BYTE;
    req.packet_byte = data_byte;
    req.last_byte   = last;
    req.entry_index = 6'($urandom);
    req.entry_port  = 16'($urandom);
    request_q.push_back(req);
    requests_sent++;
  endtask

  // Build a frame of random filler with the given header fields patched in,
  // and queue its bytes. Optionally slip one table write in mid-frame.
  task automatic queue_frame(input logic [7:0] et_hi, input logic [7:0] et_lo,
                             input logic [7:0] vihl, input logic [7:0] proto,
                             input logic [15:0] port, input int flen, input bit mid_write);
    logic [7:0] fb [$];
    int         l4_start;
    int         wpos;
    int         i;
    l4_start = 14 + 4 * int'(vihl[3:0]);
    for (i = 0; i < flen; i++) fb.push_back(8'($urandom));
    if (flen > int'(OFF_ETYPE_HI)) fb[OFF_ETYPE_HI] = et_hi;
    if (flen > int'(OFF_ETYPE_LO)) fb[OFF_ETYPE_LO] = et_lo;
    if (flen > int'(OFF_IHL))      fb[OFF_IHL]      = vihl;
    if (flen > int'(OFF_PROTO))    fb[OFF_PROTO]    = proto;
    if (flen > l4_start + 2)       fb[l4_start + 2] = port[15:8];
    if (flen > l4_start + 3)       fb[l4_start + 3] = port[7:0];
    wpos = mid_write ? $urandom_range(0, flen - 1) : -1;
    for (i = 0; i < flen; i++) begin
      if (i == wpos) queue_table_write(6'($urandom), 16'($urandom));
      queue_packet_byte(fb[i], i == flen - 1);
    end
  endtask

  // Hold the sender until every request is taken and every verdict is back,
  // then let any trailing walk finish.
  task automatic wait_idle();
    int waited;
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (WALK_SLACK) @(posedge clk);
  endtask

  // Call only while the filter is idle.
  task automatic write_blocked_count(input int count);
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_count = 7'(count);
    @(posedge clk);
  endtask

  // Load a few recognizable ports, including the top port value and the last slot.
  task automatic test_table_writes();
    queue_table_write(6'd0, 16'hFFFF);
    queue_table_write(6'd1, 16'd80);
    queue_table_write(6'd2, 16'd53);
    queue_table_write(6'd63, 16'h1234);
    wait_idle();
    write_blocked_count(3);
  endtask

  // One frame per header case; blocked ports are 0xFFFF, 80 and 53.
  task automatic test_directed_frames();
    // Blocked TCP and UDP frames at exactly the minimum length, then a longer one.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 54, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_UDP, 16'd53, 42, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'hFFFF, 60, 1'b0);
    // Parsed but not listed: zero port, and a port beyond the live count.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_UDP, 16'h0000, 50, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'h1234, 70, 1'b0);
    // One byte short of the L4 header.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 53, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_UDP, 16'd53, 41, 1'b0);
    // Runt frames: single byte, and cut inside the Ethernet header.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 1, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 13, 1'b0);
    // Largest IHL: exactly long enough, then one short.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h4F, PROTO_TCP, 16'd80, 94, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h4F, PROTO_TCP, 16'd80, 93, 1'b0);
    // IHL below the minimum header size.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h44, PROTO_TCP, 16'd80, 60, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h40, PROTO_UDP, 16'd53, 60, 1'b0);
    // Protocol other than TCP or UDP.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, 8'd1, 16'd80, 60, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, 8'hFF, 16'd80, 60, 1'b0);
    // Wrong EtherType: ARP, high byte off, low byte off.
    queue_frame(8'h08, 8'h06, 8'h45, PROTO_TCP, 16'd80, 60, 1'b0);
    queue_frame(8'h09, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 60, 1'b0);
    queue_frame(ETYPE_IPV4_HI, 8'h01, 8'h45, PROTO_TCP, 16'd80, 60, 1'b0);
    // Version nibble is not checked.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h65, PROTO_UDP, 16'd53, 42, 1'b0);
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'hF5, PROTO_TCP, 16'hFFFF, 54, 1'b0);
    // Table write landing in the middle of a frame.
    queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'd80, 54, 1'b1);
    wait_idle();
  endtask

  // Walk the count through its extremes; unwritten slots hold port zero.
  task automatic test_count_extremes();
    int counts [6] = '{0, 1, 63, 64, 65, 127};
    foreach (counts[i]) begin
      write_blocked_count(counts[i]);
      queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'hFFFF, 54, 1'b0);
      queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_TCP, 16'h1234, 54, 1'b0);
      queue_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 8'h45, PROTO_UDP, 16'h0000, 42, 1'b0);
      wait_idle();
    end
  endtask

  // Mostly well-formed TCP/UDP frames with random content, the rest short,
  // malformed or pure noise, with table writes and count changes mixed in.
  task automatic test_random(input int n_items, input int min_frames);
    int          start;
    int          frames;
    int          last_cfg;
    int          kind;
    int          ihl;
    int          span;
    int          need;
    int          cnt;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [7:0]  et_hi;
    logic [7:0]  et_lo;
    logic [15:0] port;
    bit          mid;

    start    = requests_sent;
    last_cfg = requests_sent;
    frames   = 0;
    while (requests_sent - start < n_items || frames < min_frames) begin
      if (requests_sent - last_cfg >= 400) begin
        wait_idle();
        case ($urandom_range(0, 4))
          0:       cnt = 0;
          1:       cnt = TABLE_DEPTH;
          2:       cnt = 127;
          default: cnt = $urandom_range(1, TABLE_DEPTH);
        endcase
        write_blocked_count(cnt);
        last_cfg = requests_sent;
      end

      if ($urandom_range(0, 2) == 0) queue_table_write(6'($urandom), 16'($urandom));

      ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      need  = 14 + 4 * ihl + ((proto == PROTO_TCP) ? 20 : 8);
      vihl  = {4'($urandom), 4'(ihl)};
      et_hi = ETYPE_IPV4_HI;
      et_lo = ETYPE_IPV4_LO;
      span  = (live_count == 0) ? 1 :
              ((live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count));
      // Aim at a live entry half the time so drops are common.
      port  = $urandom_range(0, 1) ? port_table[$urandom_range(0, span - 1)] : 16'($urandom);
      mid   = ($urandom_range(0, 7) == 0);
      kind  = $urandom_range(0, 9);

      case (kind)
        7: queue_frame(et_hi, et_lo, vihl, proto, port, $urandom_range(1, need - 1), mid);
        8: begin
          case ($urandom_range(0, 2))
            0:       vihl[3:0] = 4'($urandom_range(0, 4));
            1:       proto = 8'($urandom);
            default: begin
              et_hi = 8'($urandom);
              et_lo = 8'($urandom);
            end
          endcase
          queue_frame(et_hi, et_lo, vihl, proto, port, need + $urandom_range(0, 12), mid);
        end
        9: queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       16'($urandom), $urandom_range(1, 90), mid);
        default: queue_frame(et_hi, et_lo, vihl, proto, port,
                             need + $urandom_range(0, 12), mid);
      endcase
      frames++;

      // Keep the request queue short so predictions track the table closely.
      while (request_q.size() > 32) @(posedge clk);
    end
  endtask

  initial begin : main_sequence
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_blocked_count(0);
    idle_on = 1'b1;
    test_table_writes();
    test_directed_frames();
    test_count_extremes();
    test_random(250, 5);
    // Last stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random(100, 2);
    wait_idle();
    if (verdict_q.size() != 0) begin
      report_mismatch("verdicts never delivered", verdict_q.size(), 0);
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : run_limit
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[l4_dest_port_blocklist_filter.f]
+incdir+hdl
hdl/l4dpbf_pkg.sv
hdl/l4_dest_port_blocklist_filter.sv
verif/tb_top.sv
